/* hw/rtl/bffa_pkg.sv */
// ---------------------------------------------------------------------------
// bffa_pkg
// Shared widths, codes and handshake structs of the extent allocator.
// ---------------------------------------------------------------------------
package bffa_pkg;

	localparam int MAX_UNITS_DEF = 4096;
	// unit index width that covers the largest supported unit count (2^20)
	localparam int UIDX_W = 21;
	localparam int SEC_W  = 40;
	localparam int CNT_W  = 32;
	localparam int USZ_W  = 17;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	// device condition codes
	localparam logic [1:0] COND_AVAIL  = 2'd0;
	localparam logic [1:0] COND_IN_USE = 2'd1;
	localparam logic [1:0] COND_FULL   = 2'd2;

	// configuration register indexes
	localparam logic REG_UNIT_SECTORS   = 1'b0;
	localparam logic REG_DEVICE_SECTORS = 1'b1;

	// bitmap engine operations
	localparam logic [1:0] OP_SCAN  = 2'd0;
	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic              start;
		logic [1:0]        op;
		logic [UIDX_W-1:0] lo;
		logic [UIDX_W-1:0] hi;
		logic [UIDX_W-1:0] need;
		logic [UIDX_W-1:0] units;
	} bm_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic              found;
		logic [UIDX_W-1:0] first;
	} bm_rsp_t;

endpackage

/* hw/rtl/bitmap_first_fit_extent_allocator.sv */
// ---------------------------------------------------------------------------
// bitmap_first_fit_extent_allocator
// First-fit allocator of sector runs over a bitmap of allocation units.
// ---------------------------------------------------------------------------
// One request is handled at a time, and each gives one result. After reset
// the bitmap memory is swept clear, one word per cycle, and no request is
// taken meanwhile. An allocate runs two divisions on the serial divider
// (usable units, units needed), then scans the bitmap one 64-unit word at a
// time and writes the run back over each word touched, all through the single
// bitmap memory port; an allocate that needs more units than the device has
// skips the scan. A free runs three divisions and the clearing pass, and skips
// the clearing pass when its range starts past the device. A request rejected
// up front (zero-count allocate, oversized free) skips the divisions and the
// bitmap and goes straight to its result.
// A new request is taken from the cycle the result turns valid; a result
// still held by the receiver delays the one after it.
module bitmap_first_fit_extent_allocator #(
	parameter int MAX_UNITS = bffa_pkg::MAX_UNITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [39:0] cfg_wdata,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // run_base[39:0], run_length[71:40]
	input  logic        s_tuser,   // kind
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata    // status[1:0], granted_sector[41:2],
	                               // device_condition[43:42],
	                               // free_sector_total[83:44], zero[87:84]
);

	localparam int SW = bffa_pkg::SEC_W;
	localparam int UI = bffa_pkg::UIDX_W;

	localparam logic [3:0] T_IDLE = 4'd0;
	localparam logic [3:0] T_DIVU = 4'd1;
	localparam logic [3:0] T_DIVN = 4'd2;
	localparam logic [3:0] T_DIVF = 4'd3;
	localparam logic [3:0] T_BM   = 4'd4;
	localparam logic [3:0] T_OUT  = 4'd5;

	// configuration registers
	logic [bffa_pkg::USZ_W-1:0] usec_q;
	logic [SW-1:0]              dev_q;

	// state
	logic [SW-1:0] tot_q;
	logic [1:0]    cond_q;
	logic [3:0]    state_q;

	// request payload
	logic                       kind_q;
	logic [SW-1:0]              ssec_q;
	logic [bffa_pkg::CNT_W-1:0] cnt_q;
	logic [bffa_pkg::USZ_W-1:0] unit_q;
	logic [SW-1:0]              units_q, need_q, first_q;
	logic [1:0]                 res_q;
	logic [SW-1:0]              gnt_q;

	// divider
	logic          dstart_q;
	logic [SW-1:0] dvd_q;
	logic          div_busy, div_done;
	logic [SW-1:0] div_quo;

	// bitmap engine
	bffa_pkg::bm_req_t bmreq_q;
	bffa_pkg::bm_rsp_t bmrsp;

	// result register
	logic          m_tvalid_q;
	logic [1:0]    ost_q, ocd_q;
	logic [SW-1:0] ogr_q, ofr_q;

	logic          take;
	logic [SW:0]   asum;
	logic [SW-1:0] atot, ftot, fend, capq;
	logic [1:0]    acond, fcond;

	bffa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dstart_q),
		.dividend (dvd_q),
		.divisor  (unit_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	bffa_bitmap #(
		.MAX_UNITS (MAX_UNITS)
	) u_bitmap (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (bmreq_q),
		.rsp    (bmrsp)
	);

	assign take     = s_tvalid && s_tready;
	assign s_tready = (state_q == T_IDLE) && !bmrsp.busy;

	// bookkeeping for the two request kinds
	always_comb begin
		asum = {1'b0, tot_q} + (SW + 1)'(cnt_q);
		atot = asum[SW] ? {SW{1'b1}} : asum[SW-1:0];
		if (dev_q <= atot)
			acond = bffa_pkg::COND_FULL;
		else if (cond_q == bffa_pkg::COND_AVAIL)
			acond = bffa_pkg::COND_IN_USE;
		else
			acond = cond_q;
		ftot = tot_q - SW'(cnt_q);
		if (ftot == '0)
			fcond = bffa_pkg::COND_AVAIL;
		else if (cond_q == bffa_pkg::COND_FULL)
			fcond = bffa_pkg::COND_IN_USE;
		else
			fcond = cond_q;
		fend = (div_quo + need_q > units_q) ? units_q : div_quo + need_q;
		capq = (div_quo > SW'(MAX_UNITS)) ? SW'(MAX_UNITS) : div_quo;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usec_q <= bffa_pkg::USZ_W'(8);
			dev_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bffa_pkg::REG_UNIT_SECTORS:   usec_q <= cfg_wdata[bffa_pkg::USZ_W-1:0];
				bffa_pkg::REG_DEVICE_SECTORS: dev_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// request sequencer and bitmap requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= T_IDLE;
			tot_q      <= '0;
			cond_q     <= bffa_pkg::COND_AVAIL;
			dstart_q   <= 1'b0;
			bmreq_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			dstart_q      <= 1'b0;
			bmreq_q.start <= 1'b0;
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				T_IDLE: begin
					if (take) begin
						if (!s_tuser && s_tdata[71:40] == '0)
							state_q <= T_OUT;
						else if (s_tuser && SW'(s_tdata[71:40]) > tot_q)
							state_q <= T_OUT;
						else begin
							dstart_q <= 1'b1;
							state_q  <= T_DIVU;
						end
					end
				end
				T_DIVU: begin
					if (div_done) begin
						dstart_q <= 1'b1;
						state_q  <= T_DIVN;
					end
				end
				T_DIVN: begin
					if (div_done) begin
						bmreq_q.op    <= bffa_pkg::OP_SCAN;
						bmreq_q.lo    <= '0;
						bmreq_q.hi    <= '0;
						bmreq_q.need  <= UI'(div_quo);
						bmreq_q.units <= UI'(units_q);
						if (kind_q) begin
							dstart_q <= 1'b1;
							state_q  <= T_DIVF;
						end else if (div_quo > units_q) begin
							state_q <= T_OUT;
						end else begin
							bmreq_q.start <= 1'b1;
							state_q       <= T_BM;
						end
					end
				end
				T_DIVF: begin
					if (div_done) begin
						bmreq_q.op <= bffa_pkg::OP_CLEAR;
						bmreq_q.lo <= UI'(div_quo);
						bmreq_q.hi <= UI'(fend);
						if (div_quo >= units_q) begin
							tot_q   <= ftot;
							cond_q  <= fcond;
							state_q <= T_OUT;
						end else begin
							bmreq_q.start <= 1'b1;
							state_q       <= T_BM;
						end
					end
				end
				T_BM: begin
					if (bmrsp.done) begin
						if (bmreq_q.op == bffa_pkg::OP_SCAN) begin
							if (bmrsp.found) begin
								bmreq_q.start <= 1'b1;
								bmreq_q.op    <= bffa_pkg::OP_SET;
								bmreq_q.lo    <= bmrsp.first;
								bmreq_q.hi    <= bmrsp.first + bmreq_q.need;
							end else begin
								state_q <= T_OUT;
							end
						end else if (bmreq_q.op == bffa_pkg::OP_SET) begin
							tot_q   <= atot;
							cond_q  <= acond;
							state_q <= T_OUT;
						end else begin
							tot_q   <= ftot;
							cond_q  <= fcond;
							state_q <= T_OUT;
						end
					end
				end
				T_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	// request datapath
	always_ff @(posedge clk) begin
		case (state_q)
			T_IDLE: begin
				if (take) begin
					kind_q <= s_tuser;
					ssec_q <= s_tdata[39:0];
					cnt_q  <= s_tdata[71:40];
					unit_q <= (usec_q == '0) ? bffa_pkg::USZ_W'(1) : usec_q;
					dvd_q  <= dev_q;
					gnt_q  <= '0;
					res_q  <= bffa_pkg::ST_INVALID;
				end
			end
			T_DIVU: begin
				if (div_done) begin
					units_q <= capq;
					dvd_q   <= SW'(cnt_q) + SW'(unit_q) - SW'(1);
				end
			end
			T_DIVN: begin
				if (div_done) begin
					need_q <= div_quo;
					dvd_q  <= ssec_q;
					res_q  <= kind_q ? bffa_pkg::ST_OK : bffa_pkg::ST_NOSPACE;
				end
			end
			T_BM: begin
				if (bmrsp.done && bmreq_q.op == bffa_pkg::OP_SCAN && bmrsp.found) begin
					first_q <= SW'(bmrsp.first);
					gnt_q   <= SW'(bmrsp.first * unit_q);
					res_q   <= bffa_pkg::ST_OK;
				end
			end
			T_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					ost_q <= res_q;
					ogr_q <= gnt_q;
					ocd_q <= cond_q;
					ofr_q <= (dev_q > tot_q) ? dev_q - tot_q : '0;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, ofr_q, ocd_q, ogr_q, ost_q};

	// the device is available exactly when nothing is allocated
	a_cond_total: assert property (@(posedge clk) disable iff (!arst_n)
		(cond_q == bffa_pkg::COND_AVAIL) == (tot_q == '0))
		else $error("condition and allocated total disagree");

	// the divider is only started when it is idle
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dstart_q |-> !div_busy)
		else $error("divider restarted while busy");

	// a bitmap operation is only issued to an idle engine
	a_bm_idle: assert property (@(posedge clk) disable iff (!arst_n)
		bmreq_q.start |-> !bmrsp.busy)
		else $error("bitmap request while engine busy");

	// a granted run never starts past the usable units
	a_first_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_BM && bmreq_q.op == bffa_pkg::OP_SET) |-> first_q < units_q)
		else $error("granted run outside device");

endmodule

/* hw/rtl/bffa_div.sv */
// ---------------------------------------------------------------------------
// bffa_div
// Restoring divider, one quotient bit per cycle: 40-bit by 17-bit.
// ---------------------------------------------------------------------------
module bffa_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bffa_pkg::SEC_W-1:0]   dividend,
	input  logic [bffa_pkg::USZ_W-1:0]   divisor,
	output logic                         busy,
	output logic                         done,
	output logic [bffa_pkg::SEC_W-1:0]   quotient
);

	logic [5:0]                   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [bffa_pkg::USZ_W-1:0]   rem_q;
	logic [bffa_pkg::SEC_W-1:0]   quo_q;
	logic [bffa_pkg::USZ_W-1:0]   dvs_q;
	logic [bffa_pkg::USZ_W:0]     trial;
	logic [bffa_pkg::USZ_W:0]     diff;
	logic                         ge;

	// one trial subtraction
	always_comb begin
		trial = {rem_q, quo_q[bffa_pkg::SEC_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(bffa_pkg::SEC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits shift in as dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[bffa_pkg::USZ_W-1:0] : trial[bffa_pkg::USZ_W-1:0];
			quo_q <= {quo_q[bffa_pkg::SEC_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* hw/rtl/bffa_bitmap.sv */
// ---------------------------------------------------------------------------
// bffa_bitmap
// Unit bitmap memory with clear pass, first-fit word scan and range update.
// ---------------------------------------------------------------------------
module bffa_bitmap #(
	parameter int MAX_UNITS = bffa_pkg::MAX_UNITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bffa_pkg::bm_req_t req,
	output bffa_pkg::bm_rsp_t rsp
);

	localparam int WORDS = (MAX_UNITS + 63) / 64;
	localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int UI    = bffa_pkg::UIDX_W;
	localparam int CW    = bffa_pkg::UIDX_W + 2;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_EV    = 3'd3;
	localparam logic [2:0] S_WR    = 3'd4;

	logic [63:0]   bitmap_mem [WORDS];
	logic [63:0]   rd_q;
	logic [2:0]    state_q;
	logic [WA-1:0] wa_q;
	logic [WA-1:0] last_q;
	logic [1:0]    op_q;
	logic [UI-1:0] lo_q, hi_q, need_q, units_q;
	logic [CW-1:0] run_q, strt_q;
	logic          done_q, found_q;
	logic [UI-1:0] first_q;

	logic          mem_we;
	logic [63:0]   mem_wd;
	logic [CW-1:0] base;
	logic [63:0]   setv, hasb, hit, msk;
	logic [5:0]    lsb [64];
	logic [CW-1:0] run [64];
	logic [5:0]    hpos;
	logic          anyhit;
	logic [CW-1:0] hfirst, nstart;

	// memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we)
			bitmap_mem[wa_q] <= mem_wd;
		rd_q <= bitmap_mem[wa_q];
	end

	// per-word run evaluation; units past the device count as taken
	always_comb begin
		base = CW'({wa_q, 6'd0});
		for (int b = 0; b < 64; b++) begin
			setv[b] = rd_q[b] | ((base + CW'(b)) >= CW'(units_q));
			msk[b]  = ((base + CW'(b)) >= CW'(lo_q)) && ((base + CW'(b)) < CW'(hi_q));
		end
		for (int b = 0; b < 64; b++) begin
			hasb[b] = 1'b0;
			lsb[b]  = 6'd0;
			for (int j = 0; j < b; j++) begin
				if (setv[j]) begin
					hasb[b] = 1'b1;
					lsb[b]  = 6'(j);
				end
			end
			if (setv[b])
				run[b] = '0;
			else if (hasb[b])
				run[b] = CW'(b) - CW'(lsb[b]);
			else
				run[b] = run_q + CW'(b + 1);
			hit[b] = !setv[b] && (run[b] >= CW'(need_q));
		end
		hpos = 6'd0;
		for (int b = 63; b >= 0; b--) begin
			if (hit[b])
				hpos = 6'(b);
		end
		anyhit = |hit;
		if (hasb[hpos])
			hfirst = base + CW'(lsb[hpos]) + CW'(1);
		else if (run_q == '0)
			hfirst = base;
		else
			hfirst = strt_q;
		if (setv[63])
			nstart = base + CW'(64);
		else if (hasb[63])
			nstart = base + CW'(lsb[63]) + CW'(1);
		else if (run_q == '0)
			nstart = base;
		else
			nstart = strt_q;
		mem_we = (state_q == S_CLEAR) || (state_q == S_WR);
		if (state_q == S_CLEAR)
			mem_wd = '0;
		else if (op_q == bffa_pkg::OP_SET)
			mem_wd = rd_q | msk;
		else
			mem_wd = rd_q & ~msk;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			wa_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					if (wa_q == WA'(WORDS - 1)) begin
						wa_q    <= '0;
						state_q <= S_IDLE;
					end else begin
						wa_q <= wa_q + WA'(1);
					end
				end
				S_IDLE: begin
					if (req.start) begin
						if (req.op == bffa_pkg::OP_SCAN) begin
							wa_q    <= '0;
							state_q <= S_RD;
						end else if (req.hi > req.lo) begin
							wa_q    <= WA'(req.lo >> 6);
							state_q <= S_RD;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_RD: begin
					state_q <= (op_q == bffa_pkg::OP_SCAN) ? S_EV : S_WR;
				end
				S_EV: begin
					if (anyhit || wa_q == last_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						wa_q    <= wa_q + WA'(1);
						state_q <= S_RD;
					end
				end
				S_WR: begin
					if (wa_q == last_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						wa_q    <= wa_q + WA'(1);
						state_q <= S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request and scan payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.start) begin
			op_q    <= req.op;
			lo_q    <= req.lo;
			hi_q    <= req.hi;
			need_q  <= req.need;
			units_q <= req.units;
			run_q   <= '0;
			strt_q  <= '0;
			found_q <= 1'b0;
			if (req.op == bffa_pkg::OP_SCAN)
				last_q <= WA'((req.units - UI'(1)) >> 6);
			else
				last_q <= WA'((req.hi - UI'(1)) >> 6);
		end else if (state_q == S_EV) begin
			run_q  <= run[63];
			strt_q <= nstart;
			if (anyhit) begin
				found_q <= 1'b1;
				first_q <= UI'(hfirst);
			end
		end
	end

	assign rsp.busy  = (state_q != S_IDLE);
	assign rsp.done  = done_q;
	assign rsp.found = found_q;
	assign rsp.first = first_q;

endmodule
